// File: src/rfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_pkg
// Shared types, codes and lookup functions of the radio frame parser.
// ----------------------------------------------------------------------------
package rfp_pkg;

  localparam int NUM_REGS      = 8;
  localparam int PAYLOAD_DEPTH = 4;

  // Register indexes
  localparam logic [2:0] REG_START     = 3'd0;
  localparam logic [2:0] REG_ACTIVE    = 3'd1;
  localparam logic [2:0] REG_STANDBY   = 3'd2;
  localparam logic [2:0] REG_EXCHANGE  = 3'd3;
  localparam logic [2:0] REG_ALL_DATA  = 3'd4;
  localparam logic [2:0] REG_ACK       = 3'd5;
  localparam logic [2:0] REG_NAK       = 3'd6;
  localparam logic [2:0] REG_ALIVE     = 3'd7;

  localparam logic [7:0] REG_RESET [NUM_REGS] = '{
    8'd2, 8'd19, 8'd18, 8'd17, 8'd66, 8'd6, 8'd21, 8'd16
  };

  // Message kinds
  localparam logic [2:0] KIND_ACTIVE   = 3'd0;
  localparam logic [2:0] KIND_STANDBY  = 3'd1;
  localparam logic [2:0] KIND_EXCHANGE = 3'd2;
  localparam logic [2:0] KIND_ALL_DATA = 3'd3;
  localparam logic [2:0] KIND_ACK      = 3'd4;
  localparam logic [2:0] KIND_NAK      = 3'd5;
  localparam logic [2:0] KIND_ALIVE    = 3'd6;
  localparam logic [2:0] KIND_UNKNOWN  = 3'd7;

  // Frame lengths in bytes, start byte included
  localparam logic [3:0] LEN_SHORT = 4'd3;
  localparam logic [3:0] LEN_FOUR  = 4'd4;
  localparam logic [3:0] LEN_FIVE  = 4'd5;
  localparam logic [3:0] LEN_FULL  = 4'd15;

  // Frame positions with a fixed role
  localparam logic [3:0] POS_HUNT    = 4'd0;
  localparam logic [3:0] POS_SKIP    = 4'd1;
  localparam logic [3:0] POS_CODE    = 4'd2;
  localparam logic [3:0] POS_PAYLOAD = 4'd3;

  typedef struct packed {
    logic        alive_mark;
    logic [17:0] standby_khz;
    logic [17:0] active_khz;
    logic [2:0]  event_kind;
  } result_t;

  function automatic logic [3:0] kind_len(input logic [2:0] kind);
    logic [3:0] len;
    case (kind)
      KIND_ACTIVE, KIND_STANDBY, KIND_NAK: len = LEN_FIVE;
      KIND_ALL_DATA:                       len = LEN_FULL;
      KIND_ACK, KIND_ALIVE:                len = LEN_FOUR;
      default:                             len = LEN_SHORT;
    endcase
    return len;
  endfunction

  function automatic logic kind_alive(input logic [2:0] kind);
    logic alive;
    case (kind)
      KIND_ACTIVE, KIND_STANDBY, KIND_EXCHANGE, KIND_ALL_DATA, KIND_ALIVE: alive = 1'b1;
      default: alive = 1'b0;
    endcase
    return alive;
  endfunction

  // MHz byte * 1000 + step byte * 5; max 256275 fits 18 bits
  function automatic logic [17:0] freq_khz(input logic [7:0] mhz, input logic [7:0] step);
    return 18'(mhz) * 18'd1000 + 18'(step) * 18'd5;
  endfunction

endpackage

// File: src/rfp_out_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rfp_out_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module rfp_out_skid
  import rfp_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_valid,
  output logic    s_ready,
  input  result_t s_data,
  output logic    m_valid,
  input  logic    m_ready,
  output result_t m_data
);

  logic    out_valid;
  result_t out_data;
  logic    skid_valid;
  result_t skid_data;

  assign s_ready = !skid_valid;
  assign m_valid = out_valid;
  assign m_data  = out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (m_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid  <= s_valid;
      end
    end else if (s_valid && s_ready) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (m_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : s_data;
    end
    if (!(m_ready || !out_valid) && s_valid && s_ready) begin
      skid_data <= s_data;
    end
  end

`ifndef SYNTH
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid entry held without an output entry");

  a_skid_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    (!skid_valid && !(out_valid && !m_ready)) |=> !skid_valid)
    else $error("skid filled while output was free");

  a_skid_drains: assert property (@(posedge clk) disable iff (rst)
    (out_valid && m_ready && skid_valid) |=> (out_valid && !skid_valid))
    else $error("skid entry not moved to output");
`endif

endmodule

// File: src/radio_frame_parser_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radio_frame_parser_unit
// Frames received radio bytes into messages and decodes the frequencies.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle; s_tready is low only while the skid register
//   holds a result (output stalled and another frame completed); it rises
//   again after the first edge with m_tready high.
// Output: a frame's result appears on m_tvalid in the cycle after its last
//   byte is accepted when the output register is free or being taken.
// Reset (rst, synchronous): code registers take their defaults, framer goes
//   back to hunting, result buffer empties. Payload bytes are not cleared.
// ----------------------------------------------------------------------------
module radio_frame_parser_unit
  import rfp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // byte stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  // result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [17:0] active_khz, [35:18] standby_khz,
                                 // [36] alive_mark, [39:37] zero
  output logic [2:0]  m_tuser,   // [2:0] event_kind
  // configuration write requests
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  // Code registers, each read at its own fixed place
  logic [7:0] cfg_regs [NUM_REGS];

  // Framer state
  logic [3:0] frame_position;
  logic [7:0] frame_code;
  logic [7:0] payload_bytes [PAYLOAD_DEPTH];

  logic       accept;
  logic [7:0] code_now;
  logic [2:0] kind;
  logic [4:0] pos_inc;
  logic       in_frame;
  logic       done;
  logic [7:0] payload_view [PAYLOAD_DEPTH];
  result_t    result;
  logic       push;
  logic       push_ready;
  result_t    out_data;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;
  assign s_tready  = push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        cfg_regs[i] <= REG_RESET[i];
      end
    end else if (cfg_valid && cfg_ready) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  // The code byte decides the kind on the very byte that carries it
  assign code_now = (frame_position == POS_CODE) ? s_tdata : frame_code;

  // First matching register wins: scan from the last so earlier ones override
  always_comb begin
    kind = KIND_UNKNOWN;
    for (int k = NUM_REGS - 2; k >= 0; k--) begin
      if (cfg_regs[k + 1] == code_now) begin
        kind = 3'(k);
      end
    end
  end

  // Length is rechecked on every byte against the registers as they are now
  assign pos_inc  = {1'b0, frame_position} + 5'd1;
  assign in_frame = (frame_position != POS_HUNT) && (frame_position != POS_SKIP);
  assign done     = in_frame && (pos_inc >= {1'b0, kind_len(kind)});

  // Payload as it stands after this byte, so the last byte can be used at once
  always_comb begin
    for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
      payload_view[i] = (frame_position == POS_PAYLOAD + 4'(i)) ? s_tdata
                                                                  : payload_bytes[i];
    end
  end

  always_comb begin
    result.event_kind  = kind;
    result.alive_mark  = kind_alive(kind);
    result.active_khz  = '0;
    result.standby_khz = '0;
    if (kind == KIND_ACTIVE || kind == KIND_ALL_DATA) begin
      result.active_khz = freq_khz(payload_view[0], payload_view[1]);
    end
    if (kind == KIND_STANDBY) begin
      result.standby_khz = freq_khz(payload_view[0], payload_view[1]);
    end else if (kind == KIND_ALL_DATA) begin
      result.standby_khz = freq_khz(payload_view[2], payload_view[3]);
    end
  end

  assign push = accept && done;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_position <= POS_HUNT;
      frame_code     <= 8'd0;
    end else if (accept) begin
      case (frame_position)
        POS_HUNT: begin
          if (s_tdata == cfg_regs[REG_START]) begin
            frame_position <= POS_SKIP;
          end
        end
        POS_SKIP: begin
          frame_position <= POS_CODE;
        end
        default: begin
          if (frame_position == POS_CODE) begin
            frame_code <= s_tdata;
          end
          frame_position <= done ? POS_HUNT : pos_inc[3:0];
        end
      endcase
    end
  end

  // Bytes past the fourth payload byte are counted but not kept
  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < PAYLOAD_DEPTH; i++) begin
        if (frame_position == POS_PAYLOAD + 4'(i)) begin
          payload_bytes[i] <= s_tdata;
        end
      end
    end
  end

  rfp_out_skid u_out (
    .clk     (clk),
    .rst     (rst),
    .s_valid (push),
    .s_ready (push_ready),
    .s_data  (result),
    .m_valid (m_tvalid),
    .m_ready (m_tready),
    .m_data  (out_data)
  );

  assign m_tdata = {3'b000, out_data.alive_mark, out_data.standby_khz, out_data.active_khz};
  assign m_tuser = out_data.event_kind;

`ifndef SYNTH
  a_pos_below_max: assert property (@(posedge clk) disable iff (rst)
    frame_position != 4'd15)
    else $error("frame position out of range");

  a_push_in_frame: assert property (@(posedge clk) disable iff (rst)
    push |-> (frame_position >= POS_CODE))
    else $error("result pushed outside a frame");

  a_hunt_drops: assert property (@(posedge clk) disable iff (rst)
    (accept && frame_position == POS_HUNT && s_tdata != cfg_regs[REG_START])
      |=> frame_position == POS_HUNT)
    else $error("framer left hunting on a non-start byte");
`endif

endmodule
